/* design/rgblab_pkg.sv */
// Shared constants for the RGB to l-alpha-beta converter: widths, matrix
// coefficients, clamp threshold and the log2 mantissa table.
// No dependencies.
package rgblab_pkg;

	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int LMS_W     = 32;
	localparam int POS_W     = 5;
	localparam int ROM_ABITS = 6;
	localparam int ROM_DEPTH = (1 << ROM_ABITS) + 1;
	localparam int LOG_FRAC  = 24;
	localparam int ROM_W     = LOG_FRAC + 1;
	localparam int WEIGHT_W  = 16;
	localparam int DIFF_W    = 20;
	localparam int PROD_W    = DIFF_W + WEIGHT_W;
	localparam int MAG_W     = POS_W + LOG_FRAC;
	localparam int QLOG_W    = 27;
	localparam int LG_W      = QLOG_W + 1;
	localparam int ACC_W     = 58;
	localparam int OUT_W     = 21;
	localparam int RND_SH    = 2 * LOG_FRAC - 16;

	// value of the full LMS scale (2^32) in the pipeline's fraction format
	localparam int FRAC_POS = SAMPLE_W + COEF_W;

	localparam logic [63:0] THR_WIDE = ((64'd1 << FRAC_POS) + 64'd500000) / 64'd1000000;
	localparam logic [LMS_W-1:0] LMS_THR = THR_WIDE[LMS_W-1:0];

	localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

	localparam logic signed [25:0] K_INV_SQRT3     = 26'sd9686330;
	localparam logic signed [25:0] K_INV_SQRT6     = 26'sd6849270;
	localparam logic signed [25:0] K_TWO_INV_SQRT6 = 26'sd13698540;
	localparam logic signed [25:0] K_INV_SQRT2     = 26'sd11863283;

	typedef logic [COEF_W-1:0] coef_arr_t [9];

	// rows L, M, S; columns red, green, blue
	localparam coef_arr_t LMS_COEF = '{
		16'd24976, 16'd37899, 16'd2635,
		16'd12891, 16'd47474, 16'd5125,
		16'd1579,  16'd8441,  16'd55339
	};

	typedef logic [ROM_W-1:0] rom_t [ROM_DEPTH];

	// log2(1 + i/2^ROM_ABITS) in Q0.24 by repeated squaring
	function automatic logic [ROM_W-1:0] log2_entry(input int unsigned i);
		logic [63:0]       y;
		logic [ROM_W-1:0]  r;
		y = 64'(((64'd1 << ROM_ABITS) + 64'(i)) << (30 - ROM_ABITS));
		r = '0;
		if (i >= (1 << ROM_ABITS)) begin
			r = ROM_W'(1) << LOG_FRAC;
		end else begin
			for (int b = LOG_FRAC - 1; b >= 0; b--) begin
				y = (y * y) >> 30;
				if (y >= (64'd1 << 31)) begin
					r[b] = 1'b1;
					y = y >> 1;
				end
			end
		end
		return r;
	endfunction

	function automatic rom_t build_log2_rom();
		rom_t t;
		for (int i = 0; i < ROM_DEPTH; i++) begin
			t[i] = log2_entry(i);
		end
		return t;
	endfunction

	localparam rom_t LOG2_ROM = build_log2_rom();

endpackage

/* design/rgblab_lms.sv */
// RGB to LMS matrix with lower clamp, two pipeline stages.
// Uses rgblab_pkg.
module rgblab_lms (
	input  logic                          clk,
	input  logic                          en,
	input  logic [rgblab_pkg::SAMPLE_W-1:0] blue_sample,
	input  logic [rgblab_pkg::SAMPLE_W-1:0] green_sample,
	input  logic [rgblab_pkg::SAMPLE_W-1:0] red_sample,
	output logic [rgblab_pkg::LMS_W-1:0]  lms [3]
);

	logic [rgblab_pkg::LMS_W-1:0] prod_s1 [9];
	logic [rgblab_pkg::LMS_W-1:0] lms_s2 [3];
	logic [rgblab_pkg::SAMPLE_W-1:0] smp [3];
	logic [rgblab_pkg::LMS_W+1:0] sum [3];

	assign smp[0] = red_sample;
	assign smp[1] = green_sample;
	assign smp[2] = blue_sample;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				prod_s1[k] <= rgblab_pkg::LMS_W'(smp[k % 3]) *
					rgblab_pkg::LMS_W'(rgblab_pkg::LMS_COEF[k]);
			end
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum[k] = (rgblab_pkg::LMS_W+2)'(prod_s1[3*k]) +
				(rgblab_pkg::LMS_W+2)'(prod_s1[3*k+1]) +
				(rgblab_pkg::LMS_W+2)'(prod_s1[3*k+2]);
		end
	end

	// row sums stay below 2^32, so the top bits are always zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				if (sum[k][rgblab_pkg::LMS_W-1:0] <= rgblab_pkg::LMS_THR)
					lms_s2[k] <= rgblab_pkg::LMS_THR;
				else
					lms_s2[k] <= sum[k][rgblab_pkg::LMS_W-1:0];
			end
		end
	end

	assign lms = lms_s2;

endmodule

/* design/rgblab_log10.sv */
// Fixed-point log10 of one LMS value: normalise, table with interpolation,
// scale by log10(2). Five pipeline stages. Uses rgblab_pkg.
module rgblab_log10 (
	input  logic                                clk,
	input  logic                                en,
	input  logic [rgblab_pkg::LMS_W-1:0]        v,
	output logic signed [rgblab_pkg::LG_W-1:0]  lg
);

	logic [rgblab_pkg::POS_W-1:0]    pos;
	logic [rgblab_pkg::POS_W-1:0]    p_s1, p_s2, p_s3;
	logic [rgblab_pkg::LMS_W-1:0]    v_s1;
	logic [rgblab_pkg::LMS_W-1:0]    norm;
	logic [rgblab_pkg::ROM_ABITS-1:0] addr;
	logic [rgblab_pkg::ROM_W-1:0]    t0, t1;
	logic [rgblab_pkg::ROM_W-1:0]    t0_s2, t0_s3;
	logic [rgblab_pkg::DIFF_W-1:0]   diff_s2;
	logic [rgblab_pkg::WEIGHT_W-1:0] w_s2;
	logic [rgblab_pkg::PROD_W-1:0]   prod_s3;
	logic [rgblab_pkg::ROM_W-1:0]    frac;
	logic [5:0]                      ipart;
	logic [rgblab_pkg::MAG_W-1:0]    mag_s4;
	logic [60:0]                     scaled;
	logic [rgblab_pkg::QLOG_W-1:0]   q_s5;

	// index of the top set bit
	always_comb begin
		pos = '0;
		for (int i = 0; i < rgblab_pkg::LMS_W; i++) begin
			if (v[i])
				pos = rgblab_pkg::POS_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= pos;
			v_s1 <= v;
		end
	end

	assign norm = v_s1 << (5'd31 - p_s1);
	assign addr = norm[30:31-rgblab_pkg::ROM_ABITS];
	assign t0   = rgblab_pkg::LOG2_ROM[addr];
	assign t1   = rgblab_pkg::LOG2_ROM[{1'b0, addr} + 7'd1];

	always_ff @(posedge clk) begin
		if (en) begin
			t0_s2   <= t0;
			diff_s2 <= rgblab_pkg::DIFF_W'(t1 - t0);
			w_s2    <= norm[30-rgblab_pkg::ROM_ABITS -: rgblab_pkg::WEIGHT_W];
			p_s2    <= p_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s3 <= rgblab_pkg::PROD_W'(diff_s2) * rgblab_pkg::PROD_W'(w_s2);
			t0_s3   <= t0_s2;
			p_s3    <= p_s2;
		end
	end

	// log2 is (p - 32) + frac, never positive: hold its magnitude
	assign frac  = t0_s3 + rgblab_pkg::ROM_W'(prod_s3 >> 16);
	assign ipart = 6'd32 - {1'b0, p_s3};

	always_ff @(posedge clk) begin
		if (en)
			mag_s4 <= {ipart[4:0], 24'd0} - rgblab_pkg::MAG_W'(frac);
	end

	assign scaled = 61'(mag_s4) * 61'(rgblab_pkg::LOG10_2_Q32) + (61'd1 << 31);

	always_ff @(posedge clk) begin
		if (en)
			q_s5 <= scaled[32 +: rgblab_pkg::QLOG_W];
	end

	assign lg = -$signed({1'b0, q_s5});

endmodule

/* design/rgblab_out.sv */
// Output matrix from log LMS to l, alpha, beta with rounding and saturation.
// Four pipeline stages, last one is the output register. Uses rgblab_pkg.
module rgblab_out (
	input  logic                                clk,
	input  logic                                en,
	input  logic signed [rgblab_pkg::LG_W-1:0]  lg [3],
	output logic signed [rgblab_pkg::OUT_W-1:0] lum_l,
	output logic signed [rgblab_pkg::OUT_W-1:0] chroma_alpha,
	output logic signed [rgblab_pkg::OUT_W-1:0] chroma_beta
);

	localparam int AW = rgblab_pkg::ACC_W;
	localparam int OW = rgblab_pkg::OUT_W;

	logic signed [AW-1:0] sum3_s1, sum2_s1, dif_s1, lgs_s1;
	logic signed [AW-1:0] pl_s2, pa1_s2, pa2_s2, pb_s2;
	logic signed [AW-1:0] acc [3];
	logic [AW-1:0]        mag_s3 [3];
	logic                 neg_s3 [3];
	logic signed [OW-1:0] res_s4 [3];

	function automatic logic signed [OW-1:0] round_sat(input logic [AW-1:0] m,
			input logic neg);
		logic [AW-1:0] q;
		logic signed [OW-1:0] r;
		q = (m + (AW'(1) << (rgblab_pkg::RND_SH - 1))) >> rgblab_pkg::RND_SH;
		if (neg) begin
			if (q >= (AW'(1) << (OW - 1)))
				r = {1'b1, {(OW-1){1'b0}}};
			else
				r = -$signed(q[OW-1:0]);
		end else begin
			if (q >= (AW'(1) << (OW - 1)) - AW'(1))
				r = {1'b0, {(OW-1){1'b1}}};
			else
				r = $signed(q[OW-1:0]);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			sum3_s1 <= AW'(lg[0]) + AW'(lg[1]) + AW'(lg[2]);
			sum2_s1 <= AW'(lg[0]) + AW'(lg[1]);
			dif_s1  <= AW'(lg[0]) - AW'(lg[1]);
			lgs_s1  <= AW'(lg[2]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s2  <= sum3_s1 * AW'(rgblab_pkg::K_INV_SQRT3);
			pa1_s2 <= sum2_s1 * AW'(rgblab_pkg::K_INV_SQRT6);
			pa2_s2 <= lgs_s1 * AW'(rgblab_pkg::K_TWO_INV_SQRT6);
			pb_s2  <= dif_s1 * AW'(rgblab_pkg::K_INV_SQRT2);
		end
	end

	assign acc[0] = pl_s2;
	assign acc[1] = pa1_s2 - pa2_s2;
	assign acc[2] = pb_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_s3[k] <= acc[k][AW-1];
				mag_s3[k] <= acc[k][AW-1] ? AW'(-acc[k]) : AW'(acc[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				res_s4[k] <= round_sat(mag_s3[k], neg_s3[k]);
			end
		end
	end

	assign lum_l        = res_s4[0];
	assign chroma_alpha = res_s4[1];
	assign chroma_beta  = res_s4[2];

endmodule

/* design/rgb_to_lalphabeta_convert.sv */
// RGB to l-alpha-beta colour conversion, top level.
// Uses rgblab_pkg, rgblab_lms, rgblab_log10 and rgblab_out.
//
// Input channel: in_valid/in_ready with blue_sample, green_sample and
// red_sample, unsigned Q0.16. Output channel: out_valid/out_ready with
// lum_l, chroma_alpha and chroma_beta, signed Q5.16, saturated.
// Each pixel is independent; there are no configuration registers.
// Eleven register stages: two of LMS matrix, five of logarithm (normalise,
// table, interpolate, scale) and four of output matrix and rounding. One
// pixel is taken every cycle while in_ready is high.
// The whole pipeline advances together; it holds only while the output
// register is full and out_ready is low, and then in_ready is low too, so
// nothing is dropped or repeated. Reset clears the valid bits alone, so the
// block comes out of reset empty and ready.
module rgb_to_lalphabeta_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] blue_sample,
	input  logic [15:0] green_sample,
	input  logic [15:0] red_sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [20:0] lum_l,
	output logic signed [20:0] chroma_alpha,
	output logic signed [20:0] chroma_beta
);

	localparam int DEPTH = 11;

	logic                                      en;
	logic [DEPTH-1:0]                          vld_q;
	logic [rgblab_pkg::LMS_W-1:0]              lms [3];
	logic signed [rgblab_pkg::LG_W-1:0]        lg [3];

	assign en       = !vld_q[DEPTH-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[DEPTH-1];

	// advance valid bits alongside the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[DEPTH-2:0], in_valid};
		end
	end

	rgblab_lms u_lms (
		.clk          (clk),
		.en           (en),
		.blue_sample  (blue_sample),
		.green_sample (green_sample),
		.red_sample   (red_sample),
		.lms          (lms)
	);

	for (genvar k = 0; k < 3; k++) begin : g_log
		rgblab_log10 u_log (
			.clk (clk),
			.en  (en),
			.v   (lms[k]),
			.lg  (lg[k])
		);
	end

	rgblab_out u_out (
		.clk          (clk),
		.en           (en),
		.lg           (lg),
		.lum_l        (lum_l),
		.chroma_alpha (chroma_alpha),
		.chroma_beta  (chroma_beta)
	);

endmodule

/* bench/tb_top.sv */
// Self-checking bench for rgb_to_lalphabeta_convert: random and corner pixels,
// predicted l/alpha/beta compared with each output transfer.
// Depends on rgblab_pkg and the design files.
module tb_top;

	typedef struct {
		logic [15:0] blue;
		logic [15:0] green;
		logic [15:0] red;
	} pixel_t;

	typedef struct {
		logic [20:0] l;
		logic [20:0] alpha;
		logic [20:0] beta;
	} lab_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [15:0] blue_sample;
	logic [15:0] green_sample;
	logic [15:0] red_sample;
	logic out_valid;
	logic out_ready;
	logic signed [20:0] lum_l;
	logic signed [20:0] chroma_alpha;
	logic signed [20:0] chroma_beta;

	pixel_t pending_px[$];
	lab_t expected_lab[$];
	bit stim_done;
	bit in_xfer;
	int fail_cnt;
	int send_gap;
	int recv_gap;
	int hold_cycles;
	int hold_cnt;

	rgb_to_lalphabeta_convert u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.blue_sample(blue_sample), .green_sample(green_sample), .red_sample(red_sample),
		.out_valid(out_valid), .out_ready(out_ready),
		.lum_l(lum_l), .chroma_alpha(chroma_alpha), .chroma_beta(chroma_beta)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// log2(1 + i/64) in Q0.24 by repeated squaring
	function automatic longint unsigned mant_entry(input longint unsigned i);
		longint unsigned y;
		longint unsigned r;
		r = 0;
		if (i >= 64)
			return 64'd1 << 24;
		y = (64 + i) << 24;
		for (int b = 23; b >= 0; b--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				r |= 64'd1 << b;
				y >>= 1;
			end
		end
		return r;
	endfunction

	function automatic longint log10_q24(input longint unsigned v);
		int p;
		longint unsigned frac, a, w, t0, t1, lf, mag, q;
		longint l2;
		p = 63;
		while (p > 0 && v[p] == 1'b0)
			p--;
		frac = (v << (63 - p)) & 64'h7FFF_FFFF_FFFF_FFFF;
		a = frac >> 57;
		w = (frac >> 41) & 64'hFFFF;
		t0 = mant_entry(a);
		t1 = mant_entry(a + 1);
		lf = t0 + (((t1 - t0) * w) >> 16);
		l2 = (longint'(p) - 32) * (64'sd1 <<< 24) + longint'(lf);
		mag = l2 < 0 ? longint'(-l2) : l2;
		q = (mag * 64'd1292913986 + (64'd1 << 31)) >> 32;
		return l2 < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [20:0] round_sat(input longint acc);
		longint unsigned mag, q;
		mag = acc < 0 ? longint'(-acc) : acc;
		q = (mag + (64'd1 << 31)) >> 32;
		if (acc < 0)
			return q > 64'd1048576 ? 21'h100000 : 21'(-longint'(q));
		return q > 64'd1048575 ? 21'h0FFFFF : 21'(q);
	endfunction

	function automatic lab_t predict_lab(input pixel_t px);
		longint unsigned lms;
		longint lg[3];
		lab_t res;
		for (int k = 0; k < 3; k++) begin
			lms = longint'(px.red) * rgblab_pkg::LMS_COEF[3*k]
				+ longint'(px.green) * rgblab_pkg::LMS_COEF[3*k+1]
				+ longint'(px.blue) * rgblab_pkg::LMS_COEF[3*k+2];
			if (lms <= 64'd4295)
				lms = 64'd4295;
			lg[k] = log10_q24(lms);
		end
		res.l = round_sat((lg[0] + lg[1] + lg[2]) * 9686330);
		res.alpha = round_sat((lg[0] + lg[1]) * 6849270 - lg[2] * 13698540);
		res.beta = round_sat((lg[0] - lg[1]) * 11863283);
		return res;
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic pixel_t mk_px(input logic [15:0] b, input logic [15:0] g,
			input logic [15:0] r);
		pixel_t px;
		px.blue = b;
		px.green = g;
		px.red = r;
		return px;
	endfunction

	task automatic add_px(input pixel_t px);
		pending_px.insert(pending_px.size(), px);
	endtask

	initial begin
		arst_n = 1'b0;
		stim_done = 1'b0;
		fail_cnt = 0;
		// extremes, single channels, near-threshold values, walking bits
		add_px(mk_px(16'h0000, 16'h0000, 16'h0000));
		add_px(mk_px(16'hFFFF, 16'hFFFF, 16'hFFFF));
		add_px(mk_px(16'hFFFF, 16'h0000, 16'h0000));
		add_px(mk_px(16'h0000, 16'hFFFF, 16'h0000));
		add_px(mk_px(16'h0000, 16'h0000, 16'hFFFF));
		add_px(mk_px(16'h0001, 16'h0000, 16'h0000));
		add_px(mk_px(16'h0000, 16'h0001, 16'h0000));
		add_px(mk_px(16'h0000, 16'h0000, 16'h0001));
		add_px(mk_px(16'h0002, 16'h0001, 16'h0001));
		add_px(mk_px(16'hFFFF, 16'hFFFF, 16'h0000));
		add_px(mk_px(16'hFFFF, 16'h0000, 16'hFFFF));
		add_px(mk_px(16'h0000, 16'hFFFF, 16'hFFFF));
		add_px(mk_px(16'h5555, 16'hAAAA, 16'h5555));
		add_px(mk_px(16'hAAAA, 16'h5555, 16'hAAAA));
		for (int i = 0; i < 16; i += 3)
			add_px(mk_px(16'd1 << i, 16'd1 << ((i + 5) % 16),
				16'd1 << ((i + 11) % 16)));
		for (int i = 0; i < 900; i++)
			add_px(mk_px(rand_sample(), rand_sample(), rand_sample()));
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_px.size() == 0 && !in_valid);
		stim_done = 1'b1;
	end

	// driver: after each pixel draw a gap before the next, hold valid until the transfer
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			blue_sample <= '0;
			green_sample <= '0;
			red_sample <= '0;
			send_gap <= 0;
		end else if (in_valid && !in_xfer) begin
			// hold
		end else if (send_gap > 0) begin
			in_valid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_px.size() > 0) begin
			in_valid <= 1'b1;
			blue_sample <= pending_px[0].blue;
			green_sample <= pending_px[0].green;
			red_sample <= pending_px[0].red;
			void'(pending_px.pop_front());
			send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// predict at the input transfer
	always @(posedge clk) begin
		in_xfer <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			expected_lab.insert(expected_lab.size(),
				predict_lab(mk_px(blue_sample, green_sample, red_sample)));
	end

	// receiver stall: random gaps, plus one long hold-off to fill the pipeline
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_gap <= 0;
			hold_cycles <= 0;
			hold_cnt <= 0;
		end else if (hold_cycles == 200 && hold_cnt < 150) begin
			out_ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else begin
			hold_cycles <= (hold_cycles < 200) ? hold_cycles + 1 : hold_cycles;
			if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				if (out_valid)
					recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		lab_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (expected_lab.size() == 0) begin
				$error("result transfer with no expectation pending");
				fail_cnt++;
			end else begin
				exp_res = expected_lab.pop_front();
				if (lum_l !== exp_res.l) begin
					$error("lum_l: expected %0d, got %0d", $signed(exp_res.l), lum_l);
					fail_cnt++;
				end
				if (chroma_alpha !== exp_res.alpha) begin
					$error("chroma_alpha: expected %0d, got %0d", $signed(exp_res.alpha),
						chroma_alpha);
					fail_cnt++;
				end
				if (chroma_beta !== exp_res.beta) begin
					$error("chroma_beta: expected %0d, got %0d", $signed(exp_res.beta),
						chroma_beta);
					fail_cnt++;
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_lab.size() == 0);
		repeat (30) @(posedge clk);
		if (fail_cnt == 0 && expected_lab.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#200000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
